// ===== hw/rtl/tcb_pkg.sv =====
package tcb_pkg;

  // Screen geometry
  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = COLUMNS * ROWS;

  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned ADDR_W = $clog2(CELLS);

  localparam logic [7:0] BLANK   = 8'd32;
  localparam logic [7:0] NEWLINE = 8'd10;
  localparam logic [7:0] NUL     = 8'd0;

  // Command codes
  typedef enum logic [2:0] {
    CmdPut      = 3'd0,
    CmdBack     = 3'd1,
    CmdSetCur   = 3'd2,
    CmdMoveRows = 3'd3,
    CmdClrAll   = 3'd4,
    CmdClrEol   = 3'd5,
    CmdClrEos   = 3'd6,
    CmdRead     = 3'd7
  } tcb_cmd_e;

  // Operations on the screen store
  typedef enum logic [2:0] {
    MemNone,
    MemWrite,
    MemRead,
    MemScroll,
    MemInvalRow,
    MemInvalAll
  } tcb_mem_op_e;

  typedef struct packed {
    tcb_cmd_e           cmd;
    logic signed [15:0] operand_value;
    logic signed [15:0] col_request;
    logic signed [15:0] row_request;
  } tcb_in_t;

  typedef struct packed {
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    logic [7:0]       cell_char;
    logic             scrolled;
  } tcb_out_t;

  typedef struct packed {
    tcb_mem_op_e      op;
    logic [ROW_W-1:0] row;   // logical row, before rotation
    logic [COL_W-1:0] col;
    logic [7:0]       wdata;
  } tcb_mem_req_t;

  typedef struct packed {
    logic       row_valid;   // requested row holds written data
    logic [7:0] rdata;       // registered read data
  } tcb_mem_rsp_t;

  // Clamp a signed value to 0..max_v
  function automatic logic [15:0] clamp_s17(logic signed [16:0] v, logic [15:0] max_v);
    logic [15:0] r;
    if (v[16]) begin
      r = '0;
    end else if (v[15:0] > max_v) begin
      r = max_v;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/tcb_screen_mem.sv =====
module tcb_screen_mem (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tcb_pkg::tcb_mem_req_t req_i,
  output tcb_pkg::tcb_mem_rsp_t rsp_o
);

  logic [7:0]                 ram [tcb_pkg::CELLS];
  logic [7:0]                 ram_q;
  logic                       rvld_q;
  logic [tcb_pkg::ROWS-1:0]   row_vld_q;
  logic [tcb_pkg::ROW_W-1:0]  top_q;
  logic [tcb_pkg::ROW_W:0]    phys_sum;
  logic [tcb_pkg::ROW_W-1:0]  phys;
  logic [tcb_pkg::ADDR_W-1:0] addr;

  // Logical row to physical row: rotate by the scroll base
  always_comb begin
    phys_sum = {1'b0, req_i.row} + {1'b0, top_q};
    if (phys_sum >= (tcb_pkg::ROW_W+1)'(tcb_pkg::ROWS)) begin
      phys = tcb_pkg::ROW_W'(phys_sum - (tcb_pkg::ROW_W+1)'(tcb_pkg::ROWS));
    end else begin
      phys = tcb_pkg::ROW_W'(phys_sum);
    end
    addr = tcb_pkg::ADDR_W'(tcb_pkg::ADDR_W'(phys) * tcb_pkg::ADDR_W'(tcb_pkg::COLUMNS))
         + tcb_pkg::ADDR_W'(req_i.col);
  end

  // Row valid bits and scroll base; a row not valid reads as blanks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      top_q     <= '0;
      rvld_q    <= 1'b0;
    end else begin
      unique case (req_i.op)
        tcb_pkg::MemWrite:    row_vld_q[phys] <= 1'b1;
        tcb_pkg::MemRead:     rvld_q <= row_vld_q[phys];
        tcb_pkg::MemInvalRow: row_vld_q[phys] <= 1'b0;
        tcb_pkg::MemInvalAll: row_vld_q <= '0;
        tcb_pkg::MemScroll: begin
          // old top row becomes the blank bottom row
          row_vld_q[top_q] <= 1'b0;
          if (top_q == tcb_pkg::ROW_W'(tcb_pkg::ROWS - 1)) begin
            top_q <= '0;
          end else begin
            top_q <= top_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Character RAM, one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.op == tcb_pkg::MemWrite) begin
      ram[addr] <= req_i.wdata;
    end
    if (req_i.op == tcb_pkg::MemRead) begin
      ram_q <= ram[addr];
    end
  end

  assign rsp_o.row_valid = row_vld_q[phys];
  assign rsp_o.rdata     = rvld_q ? ram_q : tcb_pkg::BLANK;

endmodule

// ===== hw/rtl/text_console_buffer_top.sv =====
// Channel | Direction | Handshake                 | Beat
// in      | input     | in_valid_i / in_ready_o   | tcb_pkg::tcb_in_t
// out     | output    | out_valid_o / out_ready_i | tcb_pkg::tcb_out_t
//
// One command at a time: in_ready_o is high only while idle, after the result of the last
// command has gone into the output register. A put into a blank row writes the whole row, and
// clear to end of line and clear to end of screen step through cells, one RAM cell per cycle,
// and clear to end of screen first drops whole rows. Reset needs no clearing pass: per-row
// valid bits mark blank rows, and a scroll rotates the row base. A waiting result holds the
// next one in its last step until the register frees.
module text_console_buffer_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tcb_pkg::tcb_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tcb_pkg::tcb_out_t out_data_o
);

  typedef enum logic [3:0] {
    StIdle,
    StPut,
    StFill,
    StNewline,
    StBlank,
    StEol,
    StEosRows,
    StEosLast,
    StClrAll,
    StRead,
    StReadWait,
    StFin
  } state_e;

  localparam logic [tcb_pkg::COL_W-1:0] LastCol = tcb_pkg::COL_W'(tcb_pkg::COLUMNS - 1);
  localparam logic [tcb_pkg::COL_W-1:0] PenCol  = tcb_pkg::COL_W'(tcb_pkg::COLUMNS - 2);
  localparam logic [tcb_pkg::ROW_W-1:0] LastRow = tcb_pkg::ROW_W'(tcb_pkg::ROWS - 1);

  state_e                    state_q;
  logic [tcb_pkg::COL_W-1:0] cx_q;
  logic [tcb_pkg::ROW_W-1:0] cy_q;
  logic [tcb_pkg::COL_W-1:0] col_cnt_q;
  logic [tcb_pkg::ROW_W-1:0] row_cnt_q;
  logic [tcb_pkg::COL_W-1:0] col_req_q;
  logic [tcb_pkg::ROW_W-1:0] row_req_q;
  logic [7:0]                ch_q;
  logic [7:0]                cell_q;
  logic                      scr_q;
  logic                      eos_q;
  logic                      out_valid_q;
  tcb_pkg::tcb_out_t         out_q;

  tcb_pkg::tcb_mem_req_t     mem_req;
  tcb_pkg::tcb_mem_rsp_t     mem_rsp;

  logic [tcb_pkg::COL_W-1:0] col_clamp;
  logic [tcb_pkg::ROW_W-1:0] row_clamp;
  logic [tcb_pkg::ROW_W-1:0] move_clamp;
  logic signed [16:0]        move_sum;
  logic [7:0]                in_ch;
  logic                      in_fire;
  logic                      out_free;

  // Input-side arithmetic: clamps and row move
  always_comb begin
    col_clamp  = tcb_pkg::COL_W'(tcb_pkg::clamp_s17(
                   {in_data_i.col_request[15], in_data_i.col_request},
                   16'(tcb_pkg::COLUMNS - 1)));
    row_clamp  = tcb_pkg::ROW_W'(tcb_pkg::clamp_s17(
                   {in_data_i.row_request[15], in_data_i.row_request},
                   16'(tcb_pkg::ROWS - 1)));
    move_sum   = $signed({{(17 - tcb_pkg::ROW_W){1'b0}}, cy_q})
               + $signed({in_data_i.operand_value[15], in_data_i.operand_value});
    move_clamp = tcb_pkg::ROW_W'(tcb_pkg::clamp_s17(move_sum, 16'(tcb_pkg::ROWS - 1)));
    in_ch      = in_data_i.operand_value[7:0];
  end

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Store requests per state
  always_comb begin
    mem_req.op    = tcb_pkg::MemNone;
    mem_req.row   = cy_q;
    mem_req.col   = cx_q;
    mem_req.wdata = tcb_pkg::BLANK;
    unique case (state_q)
      StPut: begin
        if (mem_rsp.row_valid) begin
          mem_req.op    = tcb_pkg::MemWrite;
          mem_req.wdata = ch_q;
        end
      end
      StFill: begin
        mem_req.op    = tcb_pkg::MemWrite;
        mem_req.col   = col_cnt_q;
        mem_req.wdata = (col_cnt_q == cx_q) ? ch_q : tcb_pkg::BLANK;
      end
      StNewline: begin
        if (cy_q == LastRow) begin
          mem_req.op = tcb_pkg::MemScroll;
        end
      end
      StBlank: begin
        if (mem_rsp.row_valid) begin
          mem_req.op = tcb_pkg::MemWrite;
        end
      end
      StEol: begin
        mem_req.col = col_cnt_q;
        if (mem_rsp.row_valid) begin
          mem_req.op = tcb_pkg::MemWrite;
        end
      end
      StEosRows: begin
        mem_req.row = row_cnt_q;
        if (row_cnt_q != LastRow) begin
          mem_req.op = tcb_pkg::MemInvalRow;
        end
      end
      StEosLast: begin
        mem_req.row = LastRow;
        mem_req.col = col_cnt_q;
        if (mem_rsp.row_valid) begin
          mem_req.op = tcb_pkg::MemWrite;
        end
      end
      StClrAll: mem_req.op = tcb_pkg::MemInvalAll;
      StRead: begin
        mem_req.op  = tcb_pkg::MemRead;
        mem_req.row = row_req_q;
        mem_req.col = col_req_q;
      end
      default: ;
    endcase
  end

  tcb_screen_mem u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rsp_o  (mem_rsp)
  );

  // Command sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cx_q        <= '0;
      cy_q        <= '0;
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      col_req_q   <= '0;
      row_req_q   <= '0;
      ch_q        <= '0;
      cell_q      <= '0;
      scr_q       <= 1'b0;
      eos_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // the final step refills the register itself
      if (out_valid_q && out_ready_i && (state_q != StFin)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            cell_q    <= '0;
            scr_q     <= 1'b0;
            eos_q     <= (in_data_i.cmd == tcb_pkg::CmdClrEos);
            ch_q      <= in_ch;
            col_req_q <= col_clamp;
            row_req_q <= row_clamp;
            col_cnt_q <= cx_q;
            row_cnt_q <= cy_q;
            unique case (in_data_i.cmd)
              tcb_pkg::CmdPut: begin
                col_cnt_q <= '0;
                if (in_ch == tcb_pkg::NUL) begin
                  state_q <= StFin;
                end else if (in_ch == tcb_pkg::NEWLINE) begin
                  state_q <= StNewline;
                end else begin
                  state_q <= StPut;
                end
              end
              tcb_pkg::CmdBack: begin
                if (cx_q == '0) begin
                  if (cy_q != '0) begin
                    cx_q <= LastCol;
                    cy_q <= cy_q - 1'b1;
                  end
                end else begin
                  cx_q <= cx_q - 1'b1;
                end
                state_q <= StBlank;
              end
              tcb_pkg::CmdSetCur: begin
                cx_q    <= col_clamp;
                cy_q    <= row_clamp;
                state_q <= StFin;
              end
              tcb_pkg::CmdMoveRows: begin
                cy_q    <= move_clamp;
                state_q <= StFin;
              end
              tcb_pkg::CmdClrAll: state_q <= StClrAll;
              tcb_pkg::CmdClrEol: state_q <= (cx_q == '0) ? StFin : StEol;
              tcb_pkg::CmdClrEos: state_q <= (cx_q == '0) ? StEosRows : StEol;
              tcb_pkg::CmdRead:   state_q <= StRead;
              default:            state_q <= StFin;
            endcase
          end
        end
        // Character into a row that already holds data; a blank row goes to the fill
        StPut: begin
          if (mem_rsp.row_valid) begin
            if (cx_q == LastCol) begin
              state_q <= StNewline;
            end else begin
              cx_q    <= cx_q + 1'b1;
              state_q <= StFin;
            end
          end else begin
            state_q <= StFill;
          end
        end
        // First write into a blank row: lay down the whole row
        StFill: begin
          col_cnt_q <= col_cnt_q + 1'b1;
          if (col_cnt_q == LastCol) begin
            if (cx_q == LastCol) begin
              state_q <= StNewline;
            end else begin
              cx_q    <= cx_q + 1'b1;
              state_q <= StFin;
            end
          end
        end
        StNewline: begin
          cx_q <= '0;
          if (cy_q == LastRow) begin
            scr_q     <= 1'b1;
            row_cnt_q <= cy_q;
          end else begin
            cy_q      <= cy_q + 1'b1;
            row_cnt_q <= cy_q + 1'b1;
          end
          state_q <= eos_q ? StEosRows : StFin;
        end
        StBlank: state_q <= StFin;
        // Blank the rest of the row; a blank row needs no writes
        StEol: begin
          col_cnt_q <= col_cnt_q + 1'b1;
          if (!mem_rsp.row_valid || col_cnt_q == LastCol) begin
            state_q <= StNewline;
          end
        end
        // Whole rows from the current row down, all but the last row, go blank one per cycle
        StEosRows: begin
          if (row_cnt_q == LastRow) begin
            col_cnt_q <= '0;
            state_q   <= StEosLast;
          end else begin
            row_cnt_q <= row_cnt_q + 1'b1;
          end
        end
        // Last row: all but its final cell
        StEosLast: begin
          col_cnt_q <= col_cnt_q + 1'b1;
          if (!mem_rsp.row_valid || col_cnt_q == PenCol) begin
            cx_q    <= LastCol;
            cy_q    <= LastRow;
            state_q <= StFin;
          end
        end
        StClrAll: begin
          cx_q    <= '0;
          cy_q    <= '0;
          state_q <= StFin;
        end
        StRead: state_q <= StReadWait;
        StReadWait: begin
          cell_q  <= mem_rsp.rdata;
          state_q <= StFin;
        end
        // Hand the result to the output register
        StFin: begin
          if (out_free) begin
            out_valid_q      <= 1'b1;
            out_q.cursor_col <= cx_q;
            out_q.cursor_row <= cy_q;
            out_q.cell_char  <= cell_q;
            out_q.scrolled   <= scr_q;
            state_q          <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sim/tb_text_console_buffer_top.sv =====
module tb_text_console_buffer_top;

  localparam int unsigned RandomCmds  = 1000;
  // Bound on a quiet stretch, well above a full clear to end of screen plus the longest gap and stall
  localparam int unsigned IdleLimit   = 3000;
  localparam int unsigned DrainCycles = tcb_pkg::ROWS + 2 * tcb_pkg::COLUMNS + 10;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  tcb_pkg::tcb_in_t  in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  tcb_pkg::tcb_out_t out_data_o;

  // Commands waiting to be driven, and the status beats due back, oldest first
  tcb_pkg::tcb_in_t  console_cmds_q[$];
  tcb_pkg::tcb_out_t status_due_q[$];

  // Shadow of the screen and cursor
  logic [7:0]  screen_model [tcb_pkg::CELLS];
  int unsigned cur_x;
  int unsigned cur_y;

  int unsigned cmds_taken   = 0;
  int unsigned status_seen  = 0;
  int unsigned scroll_count = 0;
  int unsigned read_count   = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned send_gap     = 0;
  int unsigned recv_stall   = 0;

  text_console_buffer_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned clamp_int(int v, int unsigned lim);
    if (v < 0) return 0;
    if (v > int'(lim) - 1) return lim - 1;
    return v;
  endfunction

  // Cursor to column 0 of the next row; scroll up past the bottom row
  function automatic bit advance_row();
    int unsigned i;
    cur_x = 0;
    cur_y++;
    if (cur_y >= tcb_pkg::ROWS) begin
      for (i = 0; i < tcb_pkg::CELLS - tcb_pkg::COLUMNS; i++) begin
        screen_model[i] = screen_model[i + tcb_pkg::COLUMNS];
      end
      for (i = tcb_pkg::CELLS - tcb_pkg::COLUMNS; i < tcb_pkg::CELLS; i++) begin
        screen_model[i] = tcb_pkg::BLANK;
      end
      cur_y = tcb_pkg::ROWS - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit blank_rest_of_row();
    int unsigned i;
    if (cur_x == 0) return 1'b0;
    for (i = cur_x; i < tcb_pkg::COLUMNS; i++) begin
      screen_model[i + tcb_pkg::COLUMNS * cur_y] = tcb_pkg::BLANK;
    end
    return advance_row();
  endfunction

  // Apply one command to the shadow screen and return the status it reports
  function automatic tcb_pkg::tcb_out_t console_step(tcb_pkg::tcb_in_t c);
    tcb_pkg::tcb_out_t r;
    logic [7:0]        ch;
    int unsigned       i;
    int                sv;
    int                sc;
    int                sr;
    r  = '0;
    sv = c.operand_value;
    sc = c.col_request;
    sr = c.row_request;
    case (c.cmd)
      tcb_pkg::CmdPut: begin
        ch = c.operand_value[7:0];
        if (ch == tcb_pkg::NEWLINE) begin
          r.scrolled = advance_row();
        end else if (ch != tcb_pkg::NUL) begin
          screen_model[cur_x + tcb_pkg::COLUMNS * cur_y] = ch;
          cur_x++;
          if (cur_x >= tcb_pkg::COLUMNS) r.scrolled = advance_row();
        end
      end
      tcb_pkg::CmdBack: begin
        if (cur_x != 0) begin
          cur_x--;
        end else if (cur_y != 0) begin
          cur_x = tcb_pkg::COLUMNS - 1;
          cur_y--;
        end
        screen_model[cur_x + tcb_pkg::COLUMNS * cur_y] = tcb_pkg::BLANK;
      end
      tcb_pkg::CmdSetCur: begin
        cur_x = clamp_int(sc, tcb_pkg::COLUMNS);
        cur_y = clamp_int(sr, tcb_pkg::ROWS);
      end
      tcb_pkg::CmdMoveRows: begin
        cur_y = clamp_int(int'(cur_y) + sv, tcb_pkg::ROWS);
      end
      tcb_pkg::CmdClrAll: begin
        for (i = 0; i < tcb_pkg::CELLS; i++) screen_model[i] = tcb_pkg::BLANK;
        cur_x = 0;
        cur_y = 0;
      end
      tcb_pkg::CmdClrEol: begin
        r.scrolled = blank_rest_of_row();
      end
      tcb_pkg::CmdClrEos: begin
        // bottom-right cell keeps its content
        r.scrolled = blank_rest_of_row();
        for (i = cur_x + tcb_pkg::COLUMNS * cur_y; i < tcb_pkg::CELLS - 1; i++) begin
          screen_model[i] = tcb_pkg::BLANK;
        end
        cur_x = tcb_pkg::COLUMNS - 1;
        cur_y = tcb_pkg::ROWS - 1;
      end
      tcb_pkg::CmdRead: begin
        r.cell_char = screen_model[clamp_int(sc, tcb_pkg::COLUMNS)
                                   + tcb_pkg::COLUMNS * clamp_int(sr, tcb_pkg::ROWS)];
        read_count++;
      end
      default: ;
    endcase
    r.cursor_col = tcb_pkg::COL_W'(cur_x);
    r.cursor_row = tcb_pkg::ROW_W'(cur_y);
    if (r.scrolled) scroll_count++;
    return r;
  endfunction

  task automatic queue_cmd(tcb_pkg::tcb_cmd_e op, logic [15:0] v, logic [15:0] col,
                           logic [15:0] row);
    tcb_pkg::tcb_in_t c;
    c.cmd           = op;
    c.operand_value = v;
    c.col_request   = col;
    c.row_request   = row;
    console_cmds_q.push_back(c);
  endtask

  // Text with newlines most often, cursor moves toward the bottom rows to force scrolling
  function automatic tcb_pkg::tcb_in_t random_cmd();
    tcb_pkg::tcb_in_t c;
    int unsigned      pick;
    c.cmd           = tcb_pkg::CmdPut;
    c.operand_value = 16'($urandom);
    c.col_request   = 16'($urandom);
    c.row_request   = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      c.cmd = tcb_pkg::CmdPut;
      case ($urandom_range(0, 9))
        0: c.operand_value[7:0] = tcb_pkg::NEWLINE;
        1: c.operand_value[7:0] = tcb_pkg::NUL;
        2: ;  // any byte
        default: c.operand_value[7:0] = 8'($urandom_range(33, 126));
      endcase
    end else if (pick < 53) begin
      c.cmd = tcb_pkg::CmdBack;
    end else if (pick < 63) begin
      c.cmd = tcb_pkg::CmdSetCur;
      if ($urandom_range(0, 4) != 0) begin
        c.col_request = 16'($urandom_range(0, tcb_pkg::COLUMNS - 1));
        if ($urandom_range(0, 1)) begin
          c.row_request = 16'($urandom_range(tcb_pkg::ROWS - 3, tcb_pkg::ROWS - 1));
        end else begin
          c.row_request = 16'($urandom_range(0, tcb_pkg::ROWS - 1));
        end
      end
    end else if (pick < 69) begin
      c.cmd = tcb_pkg::CmdMoveRows;
      if ($urandom_range(0, 3) != 0) begin
        c.operand_value = 16'(int'($urandom_range(0, 8)) - 4);
      end
    end else if (pick < 71) begin
      c.cmd = tcb_pkg::CmdClrAll;
    end else if (pick < 77) begin
      c.cmd = tcb_pkg::CmdClrEol;
    end else if (pick < 80) begin
      c.cmd = tcb_pkg::CmdClrEos;
    end else begin
      c.cmd = tcb_pkg::CmdRead;
      if ($urandom_range(0, 5) != 0) begin
        c.col_request = 16'($urandom_range(0, tcb_pkg::COLUMNS - 1));
        if ($urandom_range(0, 1)) begin
          c.row_request = 16'($urandom_range(tcb_pkg::ROWS - 5, tcb_pkg::ROWS - 1));
        end else begin
          c.row_request = 16'($urandom_range(0, tcb_pkg::ROWS - 1));
        end
      end
    end
    return c;
  endfunction

  // Idle length: none in some stretches, otherwise mostly short and a few long
  function automatic int unsigned pick_delay(int unsigned n);
    int unsigned r;
    if (n % 160 < 35) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        status_due_q.push_back(console_step(in_data_i));
        cmds_taken++;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (send_gap > 0 || console_cmds_q.size() == 0) begin
          if (send_gap > 0) send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else begin
          in_data_i  <= console_cmds_q.pop_front();
          in_valid_i <= 1'b1;
          send_gap   <= pick_delay(cmds_taken);
        end
      end
    end
  end

  // Status monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    tcb_pkg::tcb_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        status_seen++;
        if (status_due_q.size() == 0) begin
          $display("%0t: status beat with nothing pending: %p", $time, out_data_o);
          mismatches++;
        end else begin
          want = status_due_q.pop_front();
          if (out_data_o.cursor_col !== want.cursor_col) begin
            $display("%0t: cursor_col expected %0d, got %0d", $time, want.cursor_col,
                     out_data_o.cursor_col);
            mismatches++;
          end
          if (out_data_o.cursor_row !== want.cursor_row) begin
            $display("%0t: cursor_row expected %0d, got %0d", $time, want.cursor_row,
                     out_data_o.cursor_row);
            mismatches++;
          end
          if (out_data_o.cell_char !== want.cell_char) begin
            $display("%0t: cell_char expected %h, got %h", $time, want.cell_char,
                     out_data_o.cell_char);
            mismatches++;
          end
          if (out_data_o.scrolled !== want.scrolled) begin
            $display("%0t: scrolled expected %b, got %b", $time, want.scrolled,
                     out_data_o.scrolled);
            mismatches++;
          end
        end
        recv_stall = pick_delay(status_seen);
      end else if (recv_stall == 0 && $urandom_range(0, 9) == 0) begin
        recv_stall = pick_delay(status_seen);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no beat for %0d cycles", $time, IdleLimit);
      $display("tb_text_console_buffer_top: errors");
      $finish;
    end
  end

  initial begin
    foreach (screen_model[n]) screen_model[n] = tcb_pkg::BLANK;
    cur_x = 0;
    cur_y = 0;

    // Directed: field extremes, ignored and newline codes, wraps, clamps, scrolls
    queue_cmd(tcb_pkg::CmdRead,     16'h0000, 16'h0000, 16'h0000);
    queue_cmd(tcb_pkg::CmdPut,      16'hC341, 16'hFFFF, 16'hFFFF);  // high byte ignored
    queue_cmd(tcb_pkg::CmdPut,      16'h7F00, 16'h0000, 16'h0000);  // NUL does nothing
    queue_cmd(tcb_pkg::CmdPut,      {8'hA5, tcb_pkg::NEWLINE}, 16'h0000, 16'h0000);
    queue_cmd(tcb_pkg::CmdPut,      16'h00FF, 16'h0000, 16'h0000);
    queue_cmd(tcb_pkg::CmdRead,     16'h0000, 16'h8000, 16'h8000);
    queue_cmd(tcb_pkg::CmdRead,     16'h0000, 16'h7FFF, 16'h7FFF);
    queue_cmd(tcb_pkg::CmdBack,     16'hFFFF, 16'h0000, 16'h0000);
    queue_cmd(tcb_pkg::CmdBack,     16'h0000, 16'h0000, 16'h0000);  // wraps to the row above
    queue_cmd(tcb_pkg::CmdSetCur,   16'h0000, 16'h0000, 16'h0000);
    queue_cmd(tcb_pkg::CmdBack,     16'h0000, 16'h0000, 16'h0000);  // stuck at home
    queue_cmd(tcb_pkg::CmdSetCur,   16'h0000, 16'h7FFF, 16'h7FFF);
    queue_cmd(tcb_pkg::CmdPut,      16'h005A, 16'h0000, 16'h0000);  // wrap on last row scrolls
    queue_cmd(tcb_pkg::CmdPut,      16'h0071, 16'h0000, 16'h0000);
    queue_cmd(tcb_pkg::CmdPut,      {8'h00, tcb_pkg::NEWLINE}, 16'h0000, 16'h0000);
    queue_cmd(tcb_pkg::CmdSetCur,   16'h0000, 16'hFFFB, 16'h8000);
    queue_cmd(tcb_pkg::CmdMoveRows, 16'h7FFF, 16'h0000, 16'h0000);
    queue_cmd(tcb_pkg::CmdMoveRows, 16'h8000, 16'h0000, 16'h0000);
    queue_cmd(tcb_pkg::CmdMoveRows, 16'h0003, 16'h0000, 16'h0000);
    queue_cmd(tcb_pkg::CmdSetCur,   16'h0000, 16'd40, 16'd24);
    queue_cmd(tcb_pkg::CmdClrEol,   16'h0000, 16'h0000, 16'h0000);  // scrolls from last row
    queue_cmd(tcb_pkg::CmdClrEol,   16'h0000, 16'h0000, 16'h0000);  // column 0: no effect
    queue_cmd(tcb_pkg::CmdPut,      16'h0078, 16'h0000, 16'h0000);
    queue_cmd(tcb_pkg::CmdClrEos,   16'h0000, 16'h0000, 16'h0000);
    queue_cmd(tcb_pkg::CmdSetCur,   16'h0000, 16'h0000, 16'd5);
    queue_cmd(tcb_pkg::CmdClrEos,   16'h0000, 16'h0000, 16'h0000);
    queue_cmd(tcb_pkg::CmdRead,     16'h0000, 16'd78, 16'd24);
    queue_cmd(tcb_pkg::CmdClrAll,   16'h0000, 16'h0000, 16'h0000);
    queue_cmd(tcb_pkg::CmdRead,     16'h0000, 16'd5, 16'd5);

    repeat (RandomCmds) console_cmds_q.push_back(random_cmd());

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sample away from the driving edge so queue and valid agree
    while (console_cmds_q.size() != 0 || in_valid_i || status_due_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (status_due_q.size() != 0 || status_seen != cmds_taken) begin
      $display("%0t: status beats expected %0d, got %0d", $time, cmds_taken, status_seen);
      mismatches++;
    end

    $display("Ran %0d console commands, %0d status beats checked.", cmds_taken, status_seen);
    $display("Screen scrolled %0d times; %0d cell reads.", scroll_count, read_count);
    if (mismatches == 0) begin
      $display("tb_text_console_buffer_top: clean");
    end else begin
      $display("tb_text_console_buffer_top: errors");
    end
    $finish;
  end

endmodule
